>>> rtl/keyframe_vector_lerp_core_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef KEYFRAME_VECTOR_LERP_CORE_DEFINES_SVH
`define KEYFRAME_VECTOR_LERP_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KVL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define KVL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/kvl_pkg.sv
// Shared types and constants for the keyframe lerp core.
// No dependencies.
package kvl_pkg;
  localparam int MaxKeys = 64;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = 7;
  localparam int TimeW = 31;
  localparam int ValW = 32;
  localparam int QDepth = 2;
  localparam logic [ValW-1:0] OneQ16 = 32'h0001_0000;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;
  localparam logic [0:0] RegKeyCount = 1'b0;
  localparam logic [0:0] RegTrackKind = 1'b1;

  typedef struct packed {
    logic              action;
    logic [5:0]        key_index;
    logic [TimeW-1:0]  key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [TimeW-1:0]  query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment_start;
    logic               between_keys;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] key_count;
    logic            track_kind;
  } cfg_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic             is_write;
    logic [5:0]       idx;
    logic [TimeW-1:0] tm;
    logic [ValW-1:0]  vx;
    logic [ValW-1:0]  vy;
    logic [ValW-1:0]  vz;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_LAST_RD, S_LAST_CHK, S_PROBE_RD, S_PROBE_CHK,
    S_PREV_RD, S_PREV_CHK, S_DIV, S_MUL, S_OUT
  } bk_state_t;
endpackage

>>> rtl/kvl_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module kvl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/kvl_front.sv
// Front end: accepts items, drops out-of-range writes, queues jobs.
// Depends on kvl_pkg.
module kvl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  kvl_pkg::in_item_t item,
  output logic              busy,
  output logic              job_valid,
  output kvl_pkg::job_t     job,
  input  logic              job_take
);
  kvl_pkg::job_t    q [kvl_pkg::QDepth];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             push;
  logic             keep;
  kvl_pkg::job_t    nj;

  assign busy = (cnt == 2'(kvl_pkg::QDepth));
  assign push = start && !busy;
  assign keep = (item.action == kvl_pkg::ActQuery) ||
                ({1'b0, item.key_index} < 7'(kvl_pkg::MaxKeys));
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  always_comb begin
    nj.is_write = (item.action == kvl_pkg::ActWrite);
    nj.idx = item.key_index;
    nj.tm = nj.is_write ? item.key_time : item.query_time;
    nj.vx = item.value_x;
    nj.vy = item.value_y;
    nj.vz = item.value_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && keep) begin
        q[wp] <= nj;
        wp <= wp + 1'b1;
      end
      if (job_valid && job_take) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + 2'(push && keep) - 2'(job_valid && job_take);
    end
  end
endmodule

>>> rtl/kvl_back.sv
// Back end: key table, binary search, divider and blend multiplier.
// Depends on kvl_pkg and kvl_ram.
module kvl_back (
  input  logic               clk,
  input  logic               rst,
  input  kvl_pkg::cfg_t      cfg,
  input  logic               job_valid,
  input  kvl_pkg::job_t      job,
  output logic               job_take,
  output logic               done,
  output kvl_pkg::out_item_t result
);
  localparam int AW = kvl_pkg::IdxW;
  localparam int RW = kvl_pkg::TimeW + 3 * kvl_pkg::ValW;

  kvl_pkg::bk_state_t state, state_next;
  kvl_pkg::job_t      cur;
  logic [AW:0]        n;
  logic [AW:0]        lower, upper, prev;
  logic [AW-1:0]      addr;
  logic               we;
  logic [RW-1:0]      rdata;
  logic [kvl_pkg::TimeW-1:0] rt;
  logic [kvl_pkg::TimeW-1:0] t0;
  logic [kvl_pkg::ValW-1:0]  a_x, a_y, a_z;
  logic [AW:0]        mid;
  logic               rd_next;
  logic [kvl_pkg::TimeW-1:0] num, den;
  logic [kvl_pkg::TimeW:0]   rem;
  logic [16:0]        f;
  logic [4:0]         step;
  logic [1:0]         comp;
  logic signed [32:0] dlt;
  logic signed [50:0] prod;
  logic signed [34:0] qv;
  logic [kvl_pkg::TimeW:0] rem_sh;

  assign n = (cfg.key_count > 7'(kvl_pkg::MaxKeys)) ? (AW+1)'(kvl_pkg::MaxKeys)
                                                     : cfg.key_count[AW:0];
  assign rt = rdata[RW-1 -: kvl_pkg::TimeW];
  assign mid = (lower + upper + 1'b1) >> 1;
  assign we = (state == kvl_pkg::S_WR);

  // Once the start key is latched, the table port stays on the next key.
  always_comb begin
    unique case (state)
      kvl_pkg::S_WR:       addr = cur.idx[AW-1:0];
      kvl_pkg::S_LAST_RD:  addr = upper[AW-1:0];
      kvl_pkg::S_PROBE_RD: addr = mid[AW-1:0];
      kvl_pkg::S_PREV_RD:  addr = rd_next ? AW'(prev + 1'b1) : prev[AW-1:0];
      default:             addr = rd_next ? AW'(prev + 1'b1) : prev[AW-1:0];
    endcase
  end

  kvl_ram #(.Width(RW), .Depth(kvl_pkg::MaxKeys)) u_ram (
    .clk(clk), .we(we), .addr(addr),
    .wdata({cur.tm, cur.vx, cur.vy, cur.vz}), .rdata(rdata)
  );

  assign rem_sh = {rem[kvl_pkg::TimeW-1:0], 1'b0};
  assign job_take = (state == kvl_pkg::S_IDLE) && job_valid;

  always_comb begin
    unique case (comp)
      2'd0:    dlt = $signed({rdata[95], rdata[95:64]}) - $signed({a_x[31], a_x});
      2'd1:    dlt = $signed({rdata[63], rdata[63:32]}) - $signed({a_y[31], a_y});
      default: dlt = $signed({rdata[31], rdata[31:0]}) - $signed({a_z[31], a_z});
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kvl_pkg::S_IDLE:
        if (job_valid) begin
          state_next = job.is_write ? kvl_pkg::S_WR
                     : (n == '0) ? kvl_pkg::S_OUT : kvl_pkg::S_LAST_RD;
        end
      kvl_pkg::S_WR:        state_next = kvl_pkg::S_IDLE;
      kvl_pkg::S_LAST_RD:   state_next = kvl_pkg::S_LAST_CHK;
      kvl_pkg::S_LAST_CHK:  state_next = (cur.tm > rt) ? kvl_pkg::S_PREV_RD
                                                       : kvl_pkg::S_PROBE_RD;
      kvl_pkg::S_PROBE_RD:
        state_next = (upper - lower <= 1) ? kvl_pkg::S_PREV_RD : kvl_pkg::S_PROBE_CHK;
      kvl_pkg::S_PROBE_CHK:
        state_next = (cur.tm == rt) ? kvl_pkg::S_PREV_RD : kvl_pkg::S_PROBE_RD;
      kvl_pkg::S_PREV_RD:   state_next = rd_next ? kvl_pkg::S_DIV : kvl_pkg::S_PREV_CHK;
      kvl_pkg::S_PREV_CHK:
        state_next = (rt >= cur.tm || prev + 1'b1 >= n) ? kvl_pkg::S_OUT
                                                        : kvl_pkg::S_PREV_RD;
      kvl_pkg::S_DIV:       state_next = (step == 5'd17) ? kvl_pkg::S_MUL : kvl_pkg::S_DIV;
      kvl_pkg::S_MUL:       state_next = (comp == 2'd2) ? kvl_pkg::S_OUT : kvl_pkg::S_MUL;
      kvl_pkg::S_OUT:       state_next = kvl_pkg::S_IDLE;
      default:              state_next = kvl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvl_pkg::S_IDLE;
      done <= 1'b0;
      rd_next <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        kvl_pkg::S_IDLE: begin
          rd_next <= 1'b0;
          if (job_valid) begin
            cur <= job;
            lower <= '0;
            upper <= n - 1'b1;
            prev <= '0;
            result.between_keys <= 1'b0;
            result.segment_start <= '0;
            result.out_x <= cfg.track_kind ? '0 : kvl_pkg::OneQ16;
            result.out_y <= cfg.track_kind ? '0 : kvl_pkg::OneQ16;
            result.out_z <= cfg.track_kind ? '0 : kvl_pkg::OneQ16;
          end
        end
        kvl_pkg::S_LAST_CHK:
          if (cur.tm > rt) prev <= upper;
        kvl_pkg::S_PROBE_RD:
          if (upper - lower <= 1) prev <= lower;
        kvl_pkg::S_PROBE_CHK: begin
          if (cur.tm < rt) upper <= mid;
          else if (cur.tm > rt) lower <= mid;
          else prev <= mid;
        end
        kvl_pkg::S_PREV_RD:
          if (rd_next) begin
            num <= cur.tm - t0;
            rem <= '0;
            f <= '0;
            step <= '0;
            comp <= 2'd0;
          end
        kvl_pkg::S_PREV_CHK: begin
          t0 <= rt;
          a_x <= rdata[95:64];
          a_y <= rdata[63:32];
          a_z <= rdata[31:0];
          result.segment_start <= 6'(prev);
          result.out_x <= rdata[95:64];
          result.out_y <= rdata[63:32];
          result.out_z <= rdata[31:0];
          rd_next <= 1'b1;
        end
        kvl_pkg::S_DIV: begin
          step <= step + 1'b1;
          if (step == 5'd0) begin
            den <= rt - t0;
            if (rt <= t0) begin
              f <= '0;
              step <= 5'd17;
            end else if (num >= rt - t0) begin
              f <= 17'h10000;
              step <= 5'd17;
            end else begin
              rem <= {1'b0, num};
            end
          end else if (step == 5'd17) begin
            prod <= dlt * $signed({1'b0, f});
          end else begin
            if (rem_sh >= {1'b0, den}) begin
              rem <= rem_sh - {1'b0, den};
              f <= {f[15:0], 1'b1};
            end else begin
              rem <= rem_sh;
              f <= {f[15:0], 1'b0};
            end
          end
        end
        kvl_pkg::S_MUL: begin
          comp <= comp + 1'b1;
          result.between_keys <= 1'b1;
          unique case (comp)
            2'd0:    result.out_x <= 32'($signed({a_x[31], a_x}) + qv);
            2'd1:    result.out_y <= 32'($signed({a_y[31], a_y}) + qv);
            default: result.out_z <= 32'($signed({a_z[31], a_z}) + qv);
          endcase
          prod <= (comp == 2'd0) ?
            ($signed({rdata[63], rdata[63:32]}) - $signed({a_y[31], a_y})) * $signed({1'b0, f}) :
            ($signed({rdata[31], rdata[31:0]}) - $signed({a_z[31], a_z})) * $signed({1'b0, f});
        end
        kvl_pkg::S_OUT: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign qv = 35'(prod >>> 16);
endmodule

>>> rtl/keyframe_vector_lerp_core.sv
// Top level of the keyframe vector lerp core.
// Depends on kvl_pkg, kvl_front, kvl_back.
//
// channel  handshake          payload
// input    start / busy       item   (kvl_pkg::in_item_t)
// result   done strobe        result (kvl_pkg::out_item_t)
// config   cfg_valid/ready    cfg_index, cfg_data
//
// In the back end a write passes through the write state only; a query runs from
// take to the done strobe through up to 6 search probes on the single table
// port, the divider and the per-component multiply. A 2-entry queue separates
// the front from the back. Reset is synchronous and empties the queue and the
// sequencer. The receiver cannot stall: done is high for one cycle per query.
module keyframe_vector_lerp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  kvl_pkg::in_item_t  item,
  output logic               done,
  output kvl_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  kvl_pkg::cfg_t cfg;
  logic          job_valid;
  logic          job_take;
  kvl_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == kvl_pkg::RegKeyCount) cfg.key_count <= cfg_data[6:0];
      else cfg.track_kind <= cfg_data[0];
    end
  end

  kvl_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  kvl_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job_valid(job_valid), .job(job),
    .job_take(job_take), .done(done), .result(result)
  );
endmodule

>>> rtl/kvl_checker.sv
// Port-level checks for the keyframe lerp core, bound to the top level.
// Depends on kvl_pkg and keyframe_vector_lerp_core_defines.svh.
`include "keyframe_vector_lerp_core_defines.svh"
module kvl_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input kvl_pkg::out_item_t result
);
  `KVL_ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "done longer than one cycle")
  `KVL_ASSERT_IMP(a_known_hs, clk, rst, 1'b1, !$isunknown({busy, done}), "busy or done unknown")
  `KVL_ASSERT_NXT(a_no_busy_idle, clk, rst, !start && !busy && !done, !busy, "busy without transfer")
endmodule

bind keyframe_vector_lerp_core kvl_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
